FILE: hw/rtl/nntc_pkg.sv
package nntc_pkg;

    // Widths of the fields and registers.
    localparam int CHAR_W          = 8;
    localparam int KIND_W          = 2;
    localparam int DELIM_W         = 32;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 32;

    // Delimiter lanes: the register holds four bytes, up to eight lanes may be built.
    localparam int DELIMITER_COUNT_DEFAULT = 4;
    localparam int MAX_DELIMITERS          = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_KIND      = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER_BYTES = CFG_INDEX_W'(1);

    // Syntax kinds.
    localparam logic [KIND_W-1:0] KIND_INTEGER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLOAT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NAME    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_POINT      = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_EXP_LOWER  = 8'h65;
    localparam logic [CHAR_W-1:0] CH_EXP_UPPER  = 8'h45;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;

    typedef struct packed {
        logic ws;
        logic digit;
        logic letter;
        logic visible;
        logic sign;
        logic expo;
        logic point;
        logic underscore;
        logic zero;
        logic term;
    } char_class_t;

    typedef enum logic [6:0] {
        PH_START      = 7'b0000001,
        PH_MANT       = 7'b0000010,
        PH_FRAC       = 7'b0000100,
        PH_EXP_WS     = 7'b0001000,
        PH_EXP_SIGNED = 7'b0010000,
        PH_EXP_DIGITS = 7'b0100000,
        PH_NAME_BODY  = 7'b1000000
    } phase_t;

endpackage

FILE: hw/rtl/nntc_classify.sv
module nntc_classify #(
    parameter int DELIMITER_COUNT = nntc_pkg::DELIMITER_COUNT_DEFAULT
) (
    input  logic [nntc_pkg::CHAR_W-1:0]  char_code,
    input  logic [nntc_pkg::DELIM_W-1:0] delimiter_bytes,
    output nntc_pkg::char_class_t        cls
);
    import nntc_pkg::*;

    // Lanes beyond the register read as zero, that is unused.
    logic [CHAR_W*MAX_DELIMITERS-1:0] delim_ext;
    logic                             delim_hit;

    assign delim_ext = (CHAR_W*MAX_DELIMITERS)'(delimiter_bytes);

    always_comb
    begin
        delim_hit = 1'b0;
        for (int i = 0; i < DELIMITER_COUNT; i++)
        begin
            if ((delim_ext[CHAR_W*i +: CHAR_W] != CH_NUL) &&
                (delim_ext[CHAR_W*i +: CHAR_W] == char_code))
            begin
                delim_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        cls.ws         = (char_code == CH_SPACE) || (char_code inside {[8'h09:8'h0D]});
        cls.digit      = char_code inside {[8'h30:8'h39]};
        cls.letter     = char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        cls.visible    = char_code inside {[8'h21:8'h7E]};
        cls.sign       = (char_code == CH_PLUS) || (char_code == CH_MINUS);
        cls.expo       = (char_code == CH_EXP_LOWER) || (char_code == CH_EXP_UPPER);
        cls.point      = (char_code == CH_POINT);
        cls.underscore = (char_code == CH_UNDERSCORE);
        cls.zero       = (char_code == CH_NUL);
        cls.term       = cls.zero || delim_hit;
    end

endmodule

FILE: hw/rtl/nntc_scan.sv
module nntc_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  nntc_pkg::char_class_t      cls,
    input  logic [nntc_pkg::KIND_W-1:0] check_kind,
    output logic                       verdict
);
    import nntc_pkg::*;

    phase_t phase_reg, phase_next;
    logic   seen_reg, seen_next;
    logic   decided_reg, decided_next;
    logic   value_reg, value_next;
    logic   flt;

    assign flt = (check_kind == KIND_FLOAT);

    always_comb
    begin
        phase_next   = phase_reg;
        seen_next    = seen_reg;
        decided_next = decided_reg;
        value_next   = value_reg;
        if (!decided_reg)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (check_kind == KIND_NONE)
                    begin
                        decided_next = 1'b1;
                        value_next   = 1'b0;
                    end
                    else if (check_kind == KIND_NAME)
                    begin
                        if (cls.underscore)
                        begin
                            phase_next = PH_START;
                        end
                        else if (cls.letter)
                        begin
                            phase_next = PH_NAME_BODY;
                        end
                        else
                        begin
                            decided_next = 1'b1;
                            value_next   = 1'b0;
                        end
                    end
                    else if (cls.ws)
                    begin
                        phase_next = PH_START;
                    end
                    else if (cls.sign)
                    begin
                        phase_next = PH_MANT;
                        seen_next  = 1'b0;
                    end
                    else if (cls.digit)
                    begin
                        phase_next = PH_MANT;
                        seen_next  = 1'b1;
                    end
                    else if (flt && cls.point)
                    begin
                        phase_next = PH_FRAC;
                        seen_next  = 1'b0;
                    end
                    else
                    begin
                        decided_next = 1'b1;
                        value_next   = 1'b0;
                    end
                end
                PH_MANT:
                begin
                    if (cls.digit)
                    begin
                        seen_next = 1'b1;
                    end
                    else if (flt && cls.point)
                    begin
                        phase_next = PH_FRAC;
                    end
                    else if (!seen_reg)
                    begin
                        decided_next = 1'b1;
                        value_next   = 1'b0;
                    end
                    else if (flt && cls.expo)
                    begin
                        phase_next = PH_EXP_WS;
                    end
                    else
                    begin
                        decided_next = 1'b1;
                        value_next   = cls.term;
                    end
                end
                PH_FRAC:
                begin
                    if (cls.digit)
                    begin
                        seen_next = 1'b1;
                    end
                    else if (!seen_reg)
                    begin
                        decided_next = 1'b1;
                        value_next   = 1'b0;
                    end
                    else if (cls.expo)
                    begin
                        phase_next = PH_EXP_WS;
                    end
                    else
                    begin
                        decided_next = 1'b1;
                        value_next   = cls.term;
                    end
                end
                PH_EXP_WS:
                begin
                    if (cls.ws)
                    begin
                        phase_next = PH_EXP_WS;
                    end
                    else if (cls.sign)
                    begin
                        phase_next = PH_EXP_SIGNED;
                    end
                    else if (cls.digit)
                    begin
                        phase_next = PH_EXP_DIGITS;
                    end
                    else
                    begin
                        decided_next = 1'b1;
                        value_next   = 1'b0;
                    end
                end
                PH_EXP_SIGNED:
                begin
                    if (cls.digit)
                    begin
                        phase_next = PH_EXP_DIGITS;
                    end
                    else
                    begin
                        decided_next = 1'b1;
                        value_next   = 1'b0;
                    end
                end
                PH_EXP_DIGITS:
                begin
                    if (!cls.digit)
                    begin
                        decided_next = 1'b1;
                        value_next   = cls.term;
                    end
                end
                PH_NAME_BODY:
                begin
                    if (cls.zero)
                    begin
                        decided_next = 1'b1;
                        value_next   = 1'b1;
                    end
                    else if (!cls.visible)
                    begin
                        decided_next = 1'b1;
                        value_next   = 1'b0;
                    end
                end
                default:
                begin
                    decided_next = 1'b1;
                    value_next   = 1'b0;
                end
            endcase
        end

        verdict = decided_next && value_next;

        // The terminator closes the word and returns the scanner to its start.
        if (cls.zero)
        begin
            phase_next   = PH_START;
            seen_next    = 1'b0;
            decided_next = 1'b0;
            value_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            seen_reg    <= 1'b0;
            decided_reg <= 1'b0;
            value_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            seen_reg    <= seen_next;
            decided_reg <= decided_next;
            value_reg   <= value_next;
        end
    end

endmodule

FILE: hw/rtl/number_name_token_checker.sv
// Checks the syntax of words that arrive one byte per request on the input channel. A zero
// byte ends a word and brings exactly one result request carrying word_valid; every other
// byte brings none. check_kind selects integer, floating-point or identifier-name syntax, and
// delimiter_bytes holds up to four bytes that may end a number early (a zero byte is unused).
// The block takes one byte per clock cycle for as long as results are taken: each byte passes
// once through the scanner state machine, which sits between a one-entry input register and
// the result register. A terminator's verdict is formed as it leaves the input register and
// is held in the result register. Only a terminator that finds the result register full and
// not being taken holds the input. The user writes configuration through the plain write port
// only while the block is idle; the block itself does not enforce this.
module number_name_token_checker #(
    parameter int DELIMITER_COUNT = nntc_pkg::DELIMITER_COUNT_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_write_en,
    input  logic [nntc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nntc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Byte input channel.
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [nntc_pkg::CHAR_W-1:0]      char_code,
    // Verdict output channel.
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             word_valid
);
    import nntc_pkg::*;

    // Configuration registers.
    logic [KIND_W-1:0]  kind_reg;
    logic [DELIM_W-1:0] delim_reg;

    // Input register: holds one accepted byte until the scanner consumes it.
    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;

    // Result register.
    logic out_valid_reg;
    logic word_valid_reg;

    char_class_t cls;
    logic        advance;
    logic        verdict;

    // A byte moves through the scanner unless it is a terminator and the result
    // register is still occupied by a verdict that is not being taken this cycle.
    assign advance  = in_valid_reg && (!cls.zero || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign out_valid  = out_valid_reg;
    assign word_valid = word_valid_reg;

    nntc_classify #(
        .DELIMITER_COUNT (DELIMITER_COUNT)
    ) u_classify (
        .char_code       (char_reg),
        .delimiter_bytes (delim_reg),
        .cls             (cls)
    );

    nntc_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cls        (cls),
        .check_kind (kind_reg),
        .verdict    (verdict)
    );

    // Configuration writes; an index outside the list writes nothing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_INTEGER;
            delim_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == CFG_CHECK_KIND)
            begin
                kind_reg <= cfg_data[KIND_W-1:0];
            end
            else if (cfg_index == CFG_DELIMITER_BYTES)
            begin
                delim_reg <= cfg_data[DELIM_W-1:0];
            end
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // The payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
        end
    end

    // Result register: loaded by a terminator, emptied when the request is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && cls.zero)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && cls.zero)
        begin
            word_valid_reg <= verdict;
        end
    end

endmodule

FILE: hw/rtl/nntc_checker.sv
module nntc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [nntc_pkg::CHAR_W-1:0]      char_code,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             word_valid
);
    import nntc_pkg::*;

    // A result request that is not taken holds its verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_valid))
        else $error("verdict changed while stalled");

    // The input only stalls behind a verdict that is waiting to be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting verdict");

    // A fresh verdict is checked against a terminator accepted earlier at the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && (char_code == CH_NUL), 2))
        else $error("verdict without a terminator");

    // A verdict taken with no terminator pending leaves the output empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && in_ready && !in_valid |=> ##1 !out_valid || $past(in_valid, 1)
            || $past(in_ready && in_valid, 1) || $past(out_valid && !out_ready, 1))
        else $error("verdict repeated");

endmodule

bind number_name_token_checker nntc_checker u_nntc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word_valid (word_valid)
);
